### sv/assert_macros.svh
// Assertion macros shared by the thermocouple converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset
`define ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`else

`define ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons)
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)

`endif

`endif

### sv/tkemf_pkg.sv
// Types, constants and coefficient tables for the type K EMF-to-temperature pipeline.
package tkemf_pkg;

  // Field widths
  localparam int EMF_W  = 24;
  localparam int TQ_W   = 20;
  localparam int RIDX_W = 2;

  // Polynomial shape and coefficient format
  localparam int NUM_TERMS      = 10;
  localparam int N_RANGES       = 3;
  localparam int COEF_FRAC_BITS = 32;

  // Datapath widths
  localparam int ACC_W     = 64;  // signed Horner accumulator
  localparam int AM_W      = 57;  // saturated accumulator magnitude
  localparam int U_W       = 17;  // in-table EMF, signed
  localparam int UM_W      = 16;  // in-table EMF magnitude
  localparam int MUL_SPLIT = 32;  // low slice width of the accumulator magnitude
  localparam int PPL_W     = MUL_SPLIT + UM_W;
  localparam int PPH_W     = (AM_W - MUL_SPLIT) + UM_W;
  localparam int N_W       = 72;  // rounded product am*um + 500

  // Divide by 1000 in base 2^22 digits, reciprocal multiply per digit
  localparam int DIG_W    = 22;
  localparam int REM_W    = 10;
  localparam int X_W      = REM_W + DIG_W;
  localparam int RECIP_W  = 33;
  localparam int DIV_K    = 42;
  localparam int PROD_W   = X_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP    = 33'd4398046512;  // ceil(2^42 / 1000)
  localparam logic [REM_W-1:0]   DIVISOR  = 10'd1000;
  localparam logic [N_W-1:0]     ROUND_MV = 72'd500;

  // Cell pipeline depth
  localparam int CELL_LAT = 10;

  // Accumulator guard
  localparam logic signed [ACC_W-1:0] ACC_LIM   = 64'sd72057594037927936;  // 2^56
  localparam logic signed [ACC_W-1:0] ACC_LIM_N = -64'sd72057594037927936;

  // Table bounds in microvolts
  localparam logic signed [EMF_W-1:0] EMF_NEG_MIN  = -24'sd5891;
  localparam logic signed [EMF_W-1:0] EMF_NEG_MAX  = 24'sd0;
  localparam logic signed [EMF_W-1:0] EMF_LOW_MIN  = 24'sd1;
  localparam logic signed [EMF_W-1:0] EMF_LOW_MAX  = 24'sd20644;
  localparam logic signed [EMF_W-1:0] EMF_HIGH_MIN = 24'sd20645;
  localparam logic signed [EMF_W-1:0] EMF_HIGH_MAX = 24'sd54886;

  // Output rounding to Q8 and saturation
  localparam int RND_SH = COEF_FRAC_BITS - 8;
  localparam logic [ACC_W-1:0] RND_HALF   = ACC_W'(1) << (COEF_FRAC_BITS - 9);
  localparam logic [ACC_W-1:0] TQ_POS_MAX = (ACC_W'(1) << (TQ_W - 1)) - ACC_W'(1);
  localparam logic [ACC_W-1:0] TQ_NEG_MAG = ACC_W'(1) << (TQ_W - 1);

  // Polynomial range codes
  typedef enum logic [RIDX_W-1:0] {
    RNG_NEG  = 2'd0,
    RNG_LOW  = 2'd1,
    RNG_HIGH = 2'd2
  } rng_t;

  // Control and side data that moves down the cell chain with each item
  typedef struct packed {
    logic                  vld;
    logic                  oor;
    rng_t                  sel;
    logic signed [U_W-1:0] u;
  } tag_t;

  // Coefficients as decimal mantissa / exponent, value = mant * 10^-exp
  localparam int DEC_MANT [N_RANGES][NUM_TERMS] = '{
    '{0, 25173462, -11662878, -10833638, -89773540,
      -37342377, -86632643, -10450598, -51920577, 0},
    '{0, 2508355, 7860106, -2503131, 8315270,
      -1228034, 9804036, -4413030, 1057734, -1052755},
    '{-1318058, 4830222, -1646031, 5464731, -9650715,
      8802193, -3110810, 0, 0, 0}
  };

  localparam int DEC_EXP [N_RANGES][NUM_TERMS] = '{
    '{0, 6, 7, 7, 8, 8, 9, 9, 11, 0},
    '{0, 5, 8, 7, 8, 8, 10, 11, 12, 14},
    '{4, 5, 6, 8, 10, 12, 14, 0, 0, 0}
  };

  // Decimal coefficient to signed fixed point, rounded half away from zero.
  // Elaboration only: restoring long division, one bit per pass.
  function automatic logic signed [ACC_W-1:0] coef_fix(input int mant, input int dexp);
    longint     m;
    logic [63:0] mag;
    logic [63:0] dv;
    logic [63:0] q;
    logic [63:0] r;
    int          i;
    m = mant;
    if (m < 0) m = -m;
    mag = 64'(m);
    dv  = 64'd1;
    for (i = 0; i < dexp; i++) dv = dv * 64'd10;
    q = '0;
    r = '0;
    // integer part
    for (i = 63; i >= 0; i--) begin
      r = {r[62:0], mag[i]};
      q = q << 1;
      if (r >= dv) begin
        r = r - dv;
        q = q | 64'd1;
      end
    end
    // fraction bits
    for (i = 0; i < COEF_FRAC_BITS; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= dv) begin
        r = r - dv;
        q = q | 64'd1;
      end
    end
    if ((r << 1) >= dv) q = q + 64'd1;
    return (mant < 0) ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [ACC_W-1:0] coef_value(input int rng, input int term);
    return coef_fix(DEC_MANT[rng][term], DEC_EXP[rng][term]);
  endfunction

endpackage

### sv/tkemf_div_digit.sv
// One base-2^22 digit of a divide by 1000: reciprocal multiply, then quotient and remainder.
module tkemf_div_digit (
  input  logic                              clk,
  input  logic [tkemf_pkg::REM_W-1:0]       rem_i,
  input  logic [tkemf_pkg::DIG_W-1:0]       chunk_i,
  output logic [tkemf_pkg::DIG_W-1:0]       quot_o,
  output logic [tkemf_pkg::REM_W-1:0]       rem_o
);
  import tkemf_pkg::*;

  logic [X_W-1:0]    x_r;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [DIG_W-1:0]  quot_r, quot_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;

  // partial dividend is below 1000 * 2^22, so the reciprocal is exact
  always_comb begin
    prod_nxt = PROD_W'({rem_i, chunk_i}) * PROD_W'(RECIP);
  end

  // remainder is below 1024, so only the low bits need computing
  always_comb begin
    quot_nxt = prod_r[DIV_K+DIG_W-1:DIV_K];
    rem_nxt  = x_r[REM_W-1:0] - REM_W'(quot_nxt[REM_W-1:0] * DIVISOR);
  end

  always_ff @(posedge clk) begin
    x_r    <= {rem_i, chunk_i};
    prod_r <= prod_nxt;
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
  end

  assign quot_o = quot_r;
  assign rem_o  = rem_r;

endmodule

### sv/tkemf_cell.sv
// One Horner cell: acc * emf / 1000 rounded, plus this cell's coefficient, in 10 stages.
module tkemf_cell #(
  parameter int TERM = tkemf_pkg::NUM_TERMS - 2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic signed [tkemf_pkg::ACC_W-1:0]  acc_i,
  input  tkemf_pkg::tag_t                     tag_i,
  output logic signed [tkemf_pkg::ACC_W-1:0]  acc_o,
  output tkemf_pkg::tag_t                     tag_o
);
  import tkemf_pkg::*;

  localparam logic signed [ACC_W-1:0] C_NEG  = coef_value(int'(RNG_NEG), TERM);
  localparam logic signed [ACC_W-1:0] C_LOW  = coef_value(int'(RNG_LOW), TERM);
  localparam logic signed [ACC_W-1:0] C_HIGH = coef_value(int'(RNG_HIGH), TERM);

  // stage 0: saturate and take magnitudes
  logic signed [ACC_W-1:0] acc_sat;
  logic [ACC_W-1:0]        acc_abs;
  logic [U_W-1:0]          u_abs;
  logic [AM_W-1:0]         am_r, am_nxt;
  logic [UM_W-1:0]         um_r, um_nxt;
  logic                    neg_nxt;
  logic                    neg_r [CELL_LAT-1];

  // stage 1 and 2: split product, then sum with rounding offset
  logic [PPL_W-1:0] pp_lo_r, pp_lo_nxt;
  logic [PPH_W-1:0] pp_hi_r, pp_hi_nxt;
  logic [N_W-1:0]   n_r, n_nxt;

  // digit chain and alignment delays
  logic [DIG_W-1:0] q1, q2, q3;
  logic [REM_W-1:0] r1, r2;
  logic [DIG_W-1:0] mid_r [2];
  logic [DIG_W-1:0] low_r [4];
  logic [DIG_W-1:0] q1_r  [4];
  logic [DIG_W-1:0] q2_r  [2];

  // final stage
  logic [3*DIG_W-1:0]      p_full;
  logic signed [ACC_W-1:0] coef;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;

  tag_t tag_r [CELL_LAT];

  // guard and magnitude of accumulator and EMF
  always_comb begin
    if (acc_i > ACC_LIM) begin
      acc_sat = ACC_LIM;
    end else if (acc_i < ACC_LIM_N) begin
      acc_sat = ACC_LIM_N;
    end else begin
      acc_sat = acc_i;
    end
    acc_abs = acc_sat[ACC_W-1] ? ACC_W'(-acc_sat) : ACC_W'(acc_sat);
    am_nxt  = acc_abs[AM_W-1:0];
    u_abs   = tag_i.u[U_W-1] ? U_W'(-tag_i.u) : U_W'(tag_i.u);
    um_nxt  = u_abs[UM_W-1:0];
    neg_nxt = acc_i[ACC_W-1] ^ tag_i.u[U_W-1];
  end

  // partial products of magnitude times EMF
  always_comb begin
    pp_lo_nxt = PPL_W'(am_r[MUL_SPLIT-1:0]) * PPL_W'(um_r);
    pp_hi_nxt = PPH_W'(am_r[AM_W-1:MUL_SPLIT]) * PPH_W'(um_r);
  end

  // full product plus half of the divisor
  always_comb begin
    n_nxt = (N_W'(pp_hi_r) << MUL_SPLIT) + N_W'(pp_lo_r) + ROUND_MV;
  end

  // divide by 1000 in three digits; top six bits are already below 1000
  tkemf_div_digit u_dig1 (
    .clk     (clk),
    .rem_i   (REM_W'(n_r[N_W-1:3*DIG_W])),
    .chunk_i (n_r[3*DIG_W-1:2*DIG_W]),
    .quot_o  (q1),
    .rem_o   (r1)
  );

  tkemf_div_digit u_dig2 (
    .clk     (clk),
    .rem_i   (r1),
    .chunk_i (mid_r[1]),
    .quot_o  (q2),
    .rem_o   (r2)
  );

  tkemf_div_digit u_dig3 (
    .clk     (clk),
    .rem_i   (r2),
    .chunk_i (low_r[3]),
    .quot_o  (q3),
    .rem_o   ()
  );

  // coefficient for this term, by range
  always_comb begin
    unique case (tag_r[CELL_LAT-2].sel)
      RNG_NEG:  coef = C_NEG;
      RNG_LOW:  coef = C_LOW;
      RNG_HIGH: coef = C_HIGH;
      default:  coef = '0;
    endcase
  end

  // signed product back in, then add coefficient
  always_comb begin
    p_full = {q1_r[3], q2_r[1], q3};
    if (neg_r[CELL_LAT-2]) begin
      acc_nxt = coef - $signed(p_full[ACC_W-1:0]);
    end else begin
      acc_nxt = coef + $signed(p_full[ACC_W-1:0]);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    am_r    <= am_nxt;
    um_r    <= um_nxt;
    pp_lo_r <= pp_lo_nxt;
    pp_hi_r <= pp_hi_nxt;
    n_r     <= n_nxt;
    acc_r   <= acc_nxt;

    neg_r[0] <= neg_nxt;
    for (int k = 1; k < CELL_LAT - 1; k++) neg_r[k] <= neg_r[k-1];

    mid_r[0] <= n_r[2*DIG_W-1:DIG_W];
    mid_r[1] <= mid_r[0];

    low_r[0] <= n_r[DIG_W-1:0];
    for (int k = 1; k < 4; k++) low_r[k] <= low_r[k-1];

    q1_r[0] <= q1;
    for (int k = 1; k < 4; k++) q1_r[k] <= q1_r[k-1];

    q2_r[0] <= q2;
    q2_r[1] <= q2_r[0];
  end

  // item tags move with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CELL_LAT; k++) tag_r[k] <= '0;
    end else begin
      tag_r[0] <= tag_i;
      for (int k = 1; k < CELL_LAT; k++) tag_r[k] <= tag_r[k-1];
    end
  end

  assign acc_o = acc_r;
  assign tag_o = tag_r[CELL_LAT-1];

endmodule

### sv/type_k_emf_to_temp_core.sv
// Top level: type K thermocouple EMF to temperature, pipelined Horner cell chain.
//
// Input: drive in_emf_uv (signed microvolts, cold junction at 0 degC) and
// raise start; the sample transfers at a rising edge where start is high and
// busy is low. busy is high only in reset and the cycle after it, so one
// sample can transfer on every clock.
// Output: each sample gives one result. out_valid is high for one cycle with
// out_temp_q8 (degC * 256), out_of_range and out_range_index; it transfers at
// the edge that ends that cycle. Results leave in input order.
// Path: the entry register loads at the transfer edge, then nine Horner
// cells of ten stages each and three output rounding stages.
// Throughput: one sample per clock. Each cell's depth is set by its
// 57x16 product followed by three reciprocal-multiply digits of a divide by
// 1000, each digit two stages.
// Out-of-table EMF (outside -5891..54886 uV) gives temperature 0, range 0
// and out_of_range set.
// Reset (synchronous, rst_n low) drops every item in flight; no result is
// shown until new samples arrive. The receiver cannot hold results off.
`include "assert_macros.svh"

module type_k_emf_to_temp_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [tkemf_pkg::EMF_W-1:0]   in_emf_uv,
  output logic                                 out_valid,
  output logic signed [tkemf_pkg::TQ_W-1:0]    out_temp_q8,
  output logic                                 out_of_range,
  output logic [tkemf_pkg::RIDX_W-1:0]         out_range_index
);
  import tkemf_pkg::*;

  localparam int N_CELLS = NUM_TERMS - 1;

  localparam logic signed [ACC_W-1:0] C_TOP_NEG  = coef_value(int'(RNG_NEG), NUM_TERMS - 1);
  localparam logic signed [ACC_W-1:0] C_TOP_LOW  = coef_value(int'(RNG_LOW), NUM_TERMS - 1);
  localparam logic signed [ACC_W-1:0] C_TOP_HIGH = coef_value(int'(RNG_HIGH), NUM_TERMS - 1);

  logic busy_r;
  logic accept;

  // entry stage
  rng_t                    sel;
  logic                    oor;
  tag_t                    tag0_nxt;
  logic signed [ACC_W-1:0] acc0_nxt;
  tag_t                    tag0_r;
  logic signed [ACC_W-1:0] acc0_r;

  // cell chain: index 0 is the entry register, the last is the final cell
  logic signed [ACC_W-1:0] acc_chain [NUM_TERMS];
  tag_t                    tag_chain [NUM_TERMS];

  // output rounding stages
  logic [ACC_W-1:0] omag_r, omag_nxt;
  logic             oneg1_r;
  tag_t             otag1_r;
  logic [ACC_W-1:0] rnd_r, rnd_nxt;
  logic             oneg2_r;
  tag_t             otag2_r;
  logic [ACC_W-1:0] lim;
  logic [ACC_W-1:0] mclip;
  logic [TQ_W-1:0]  temp_nxt;

  logic                    out_valid_r;
  logic signed [TQ_W-1:0]  out_temp_q8_r;
  logic                    out_of_range_r;
  logic [RIDX_W-1:0]       out_range_index_r;

  // busy only covers reset and the cycle after
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // range select
  always_comb begin
    sel = RNG_NEG;
    oor = 1'b0;
    if (in_emf_uv >= EMF_NEG_MIN && in_emf_uv <= EMF_NEG_MAX) begin
      sel = RNG_NEG;
    end else if (in_emf_uv >= EMF_LOW_MIN && in_emf_uv <= EMF_LOW_MAX) begin
      sel = RNG_LOW;
    end else if (in_emf_uv >= EMF_HIGH_MIN && in_emf_uv <= EMF_HIGH_MAX) begin
      sel = RNG_HIGH;
    end else begin
      oor = 1'b1;
    end
  end

  // tag and leading coefficient
  always_comb begin
    tag0_nxt.vld = accept;
    tag0_nxt.oor = oor;
    tag0_nxt.sel = sel;
    tag0_nxt.u   = oor ? '0 : U_W'(in_emf_uv);
    unique case (sel)
      RNG_NEG:  acc0_nxt = C_TOP_NEG;
      RNG_LOW:  acc0_nxt = C_TOP_LOW;
      RNG_HIGH: acc0_nxt = C_TOP_HIGH;
      default:  acc0_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    acc0_r <= acc0_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag0_r <= '0;
    end else begin
      tag0_r <= tag0_nxt;
    end
  end

  assign acc_chain[0] = acc0_r;
  assign tag_chain[0] = tag0_r;

  // Horner cells, highest term first
  for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
    tkemf_cell #(
      .TERM (NUM_TERMS - 2 - g)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .acc_i (acc_chain[g]),
      .tag_i (tag_chain[g]),
      .acc_o (acc_chain[g+1]),
      .tag_o (tag_chain[g+1])
    );
  end

  // magnitude of the final accumulator
  always_comb begin
    omag_nxt = acc_chain[NUM_TERMS-1][ACC_W-1] ? ACC_W'(-acc_chain[NUM_TERMS-1])
                                               : ACC_W'(acc_chain[NUM_TERMS-1]);
  end

  // round to Q8, half away from zero
  always_comb begin
    rnd_nxt = (omag_r + RND_HALF) >> RND_SH;
  end

  // saturate to the output range and restore sign
  always_comb begin
    lim      = oneg2_r ? TQ_NEG_MAG : TQ_POS_MAX;
    mclip    = (rnd_r > lim) ? lim : rnd_r;
    temp_nxt = oneg2_r ? TQ_W'(-mclip[TQ_W-1:0]) : mclip[TQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    omag_r  <= omag_nxt;
    oneg1_r <= acc_chain[NUM_TERMS-1][ACC_W-1];
    rnd_r   <= rnd_nxt;
    oneg2_r <= oneg1_r;
    if (otag2_r.oor) begin
      out_temp_q8_r     <= '0;
      out_of_range_r    <= 1'b1;
      out_range_index_r <= RNG_NEG;
    end else begin
      out_temp_q8_r     <= $signed(temp_nxt);
      out_of_range_r    <= 1'b0;
      out_range_index_r <= otag2_r.sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      otag1_r     <= '0;
      otag2_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      otag1_r     <= tag_chain[NUM_TERMS-1];
      otag2_r     <= otag1_r;
      out_valid_r <= otag2_r.vld;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_temp_q8     = out_temp_q8_r;
  assign out_of_range    = out_of_range_r;
  assign out_range_index = out_range_index_r;

  // checks
  `ASSERT_NEXT(a_busy_clears, clk, rst_n, 1'b1, !busy)
  `ASSERT_IMPL(a_oor_zero, clk, rst_n, out_valid && out_of_range, out_temp_q8 == '0 && out_range_index == RNG_NEG)
  `ASSERT_IMPL(a_neg_range_sign, clk, rst_n, out_valid && !out_of_range && out_range_index == RNG_NEG, out_temp_q8[TQ_W-1] || out_temp_q8 == '0)
  `ASSERT_IMPL(a_pos_range_sign, clk, rst_n, out_valid && !out_of_range && out_range_index != RNG_NEG, !out_temp_q8[TQ_W-1])

endmodule
